[rtl/pvu_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvu_pkg
// Shared types and codes of the PCM volume and interpolation upsampler.
// ----------------------------------------------------------------------------
package pvu_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int VOL_W      = 8;
  localparam int MODE_W     = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_VOLUME = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEREO = 2'd2;

  // upsample modes, the unused code acts as 1x
  localparam logic [MODE_W-1:0] MODE_1X = 2'd0;
  localparam logic [MODE_W-1:0] MODE_2X = 2'd1;
  localparam logic [MODE_W-1:0] MODE_4X = 2'd2;

  localparam logic [VOL_W-1:0] VOLUME_UNITY = 8'd16;

  // lane result taps
  localparam int NUM_TAPS = 5;
  localparam int TAP_PREV = 0;
  localparam int TAP_Q1   = 1;
  localparam int TAP_HALF = 2;
  localparam int TAP_Q3   = 3;
  localparam int TAP_CUR  = 4;

  // per-lane stage enables
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic upd;
  } pvu_en_t;

endpackage

[rtl/pvu_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvu_in_if
// Input channel: one stereo sample pair and a silence flag per item.
// ----------------------------------------------------------------------------
interface pvu_in_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] left_sample;
  logic signed [SAMPLE_WIDTH-1:0] right_sample;
  logic                           silence;

  modport source (output valid, left_sample, right_sample, silence, input ready);
  modport sink   (input valid, left_sample, right_sample, silence, output ready);
endinterface

[rtl/pvu_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvu_out_if
// Result channel: one output sample pair per item, flagged when last of run.
// ----------------------------------------------------------------------------
interface pvu_out_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] out_left;
  logic signed [SAMPLE_WIDTH-1:0] out_right;
  logic                           last_of_run;

  modport source (output valid, out_left, out_right, last_of_run, input ready);
  modport sink   (input valid, out_left, out_right, last_of_run, output ready);
endinterface

[rtl/pvu_lane.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvu_lane
// One channel datapath: gain multiply, divide by 16 with saturation, then
// linear interpolation against the previous scaled sample.
// ----------------------------------------------------------------------------
module pvu_lane
  import pvu_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  pvu_en_t                              en,
  input  logic signed [SAMPLE_WIDTH-1:0]       sample,
  input  logic        [VOL_W-1:0]              volume,
  output logic        [NUM_TAPS-1:0][SAMPLE_WIDTH-1:0] taps
);

  localparam int PW = SAMPLE_WIDTH + VOL_W + 1;

  localparam logic signed [PW-1:0] SAT_HI =
    {{(PW-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [PW-1:0] SAT_LO = ~SAT_HI;

  // truncating average of two samples
  function automatic logic signed [SAMPLE_WIDTH-1:0] avg2(
    input logic signed [SAMPLE_WIDTH-1:0] a,
    input logic signed [SAMPLE_WIDTH-1:0] b
  );
    logic signed [SAMPLE_WIDTH:0] sum;
    logic signed [SAMPLE_WIDTH:0] adj;
    sum  = (SAMPLE_WIDTH+1)'(a) + (SAMPLE_WIDTH+1)'(b);
    adj  = sum + {{SAMPLE_WIDTH{1'b0}}, sum[SAMPLE_WIDTH]};
    avg2 = adj[SAMPLE_WIDTH:1];
  endfunction

  logic signed [PW-1:0]           prod_r, prod_nxt;
  logic signed [PW-1:0]           biased, quo;
  logic signed [SAMPLE_WIDTH-1:0] cur_r, cur_nxt;
  logic signed [SAMPLE_WIDTH-1:0] prev_r;
  logic signed [SAMPLE_WIDTH-1:0] half, q1, q3;
  logic        [NUM_TAPS-1:0][SAMPLE_WIDTH-1:0] taps_r, taps_nxt;

  assign prod_nxt = PW'(sample) * PW'(signed'({1'b0, volume}));

  // divide by 16 toward zero, then clamp
  always_comb begin
    biased = prod_r + {{(PW-4){1'b0}}, {4{prod_r[PW-1]}}};
    quo    = biased >>> 4;
    if (quo > SAT_HI) begin
      cur_nxt = SAT_HI[SAMPLE_WIDTH-1:0];
    end else if (quo < SAT_LO) begin
      cur_nxt = SAT_LO[SAMPLE_WIDTH-1:0];
    end else begin
      cur_nxt = quo[SAMPLE_WIDTH-1:0];
    end
  end

  always_comb begin
    half = avg2(prev_r, cur_r);
    q1   = avg2(prev_r, half);
    q3   = avg2(half, cur_r);
    taps_nxt           = '0;
    taps_nxt[TAP_PREV] = prev_r;
    taps_nxt[TAP_Q1]   = q1;
    taps_nxt[TAP_HALF] = half;
    taps_nxt[TAP_Q3]   = q3;
    taps_nxt[TAP_CUR]  = cur_r;
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      prod_r <= prod_nxt;
    end
    if (en.s2) begin
      cur_r <= cur_nxt;
    end
    if (en.s3) begin
      taps_r <= taps_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
    end else if (en.s3 && en.upd) begin
      prev_r <= cur_r;
    end
  end

  assign taps = taps_r;

endmodule

[rtl/pvu_merge.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvu_merge
// Joins the two lane results into a run of 1, 2 or 4 output pairs and
// plays the run out one pair per cycle while out_ch.ready is high.
// ----------------------------------------------------------------------------
module pvu_merge
  import pvu_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic [MODE_W-1:0]                        mode,
  input  logic                                     grp_valid,
  output logic                                     grp_ready,
  input  logic                                     grp_silence,
  input  logic [NUM_TAPS-1:0][SAMPLE_WIDTH-1:0]    taps_l,
  input  logic [NUM_TAPS-1:0][SAMPLE_WIDTH-1:0]    taps_r,
  pvu_out_if.source                                out_ch
);

  logic [3:0][SAMPLE_WIDTH-1:0] ent_l_r, ent_l_nxt;
  logic [3:0][SAMPLE_WIDTH-1:0] ent_r_r, ent_r_nxt;
  logic [1:0]                   idx_r;
  logic [1:0]                   last_r, last_nxt;
  logic                         busy_r;
  logic                         pop, pop_last, load;

  assign pop       = busy_r && out_ch.ready;
  assign pop_last  = pop && (idx_r == last_r);
  assign grp_ready = !busy_r || pop_last;
  assign load      = grp_valid && grp_ready;

  always_comb begin
    ent_l_nxt = '0;
    ent_r_nxt = '0;
    case (mode)
      MODE_2X: begin
        last_nxt     = 2'd1;
        ent_l_nxt[0] = taps_l[TAP_PREV];
        ent_r_nxt[0] = taps_r[TAP_PREV];
        ent_l_nxt[1] = taps_l[TAP_HALF];
        ent_r_nxt[1] = taps_r[TAP_HALF];
      end
      MODE_4X: begin
        last_nxt     = 2'd3;
        ent_l_nxt[0] = taps_l[TAP_PREV];
        ent_r_nxt[0] = taps_r[TAP_PREV];
        ent_l_nxt[1] = taps_l[TAP_Q1];
        ent_r_nxt[1] = taps_r[TAP_Q1];
        ent_l_nxt[2] = taps_l[TAP_HALF];
        ent_r_nxt[2] = taps_r[TAP_HALF];
        ent_l_nxt[3] = taps_l[TAP_Q3];
        ent_r_nxt[3] = taps_r[TAP_Q3];
      end
      default: begin
        last_nxt     = 2'd0;
        ent_l_nxt[0] = taps_l[TAP_CUR];
        ent_r_nxt[0] = taps_r[TAP_CUR];
      end
    endcase
    // underrun: same run length, all zero
    if (grp_silence) begin
      ent_l_nxt = '0;
      ent_r_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ent_l_r <= ent_l_nxt;
      ent_r_r <= ent_r_nxt;
      last_r  <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (load) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
    end else if (pop_last) begin
      busy_r <= 1'b0;
    end else if (pop) begin
      idx_r <= idx_r + 2'd1;
    end
  end

  assign out_ch.valid       = busy_r;
  assign out_ch.out_left    = ent_l_r[idx_r];
  assign out_ch.out_right   = ent_r_r[idx_r];
  assign out_ch.last_of_run = (idx_r == last_r);

endmodule

[rtl/pcm_volume_interp_upsampler.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_volume_interp_upsampler
// Stereo volume stage with 1x/2x/4x linear interpolation upsampling.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch takes one stereo pair per item (valid/ready). Each pair is scaled
//   by volume/16 with saturation, then 1, 2 or 4 pairs leave on out_ch, the
//   last flagged by last_of_run. Silence items give zero pairs and keep the
//   interpolation history. Mono mode feeds the left sample to both lanes.
//   cfg_we/cfg_index/cfg_data write volume, upsample mode and stereo; write
//   them only while no item is in flight.
// Path: the first pair of an item passes the multiply, scale/saturate and
//   interpolate stages and then the output buffer.
// Flow: the output buffer plays a run out one pair per cycle while
//   out_ch.ready is high; a new item enters every cycle while the stages
//   ahead have room.
// Stall: when out_ch.ready is low the output buffer holds, the three
//   stages fill up and then in_ch.ready drops.
// Reset: volume 16, 1x mode, stereo; history cleared to zero; no items.
// ----------------------------------------------------------------------------
module pcm_volume_interp_upsampler
  import pvu_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  pvu_in_if.sink                in_ch,
  pvu_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [VOL_W-1:0]  volume_r;
  logic [MODE_W-1:0] mode_r;
  logic              stereo_r;

  logic v1_r, v2_r, v3_r;
  logic sil1_r, sil2_r, sil3_r;
  logic rdy1, rdy2, rdy3;
  logic grp_ready;
  logic interp;
  pvu_en_t en;

  logic signed [SAMPLE_WIDTH-1:0]             right_src;
  logic [NUM_TAPS-1:0][SAMPLE_WIDTH-1:0]      taps_l, taps_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      volume_r <= VOLUME_UNITY;
      mode_r   <= MODE_1X;
      stereo_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_VOLUME: volume_r <= cfg_data[VOL_W-1:0];
        REG_MODE:   mode_r   <= cfg_data[MODE_W-1:0];
        REG_STEREO: stereo_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // stage handshake, each stage moves when the one after has room
  assign rdy3 = !v3_r || grp_ready;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_ch.ready = rdy1;

  assign interp = (mode_r == MODE_2X) || (mode_r == MODE_4X);

  always_comb begin
    en.s1  = in_ch.valid && rdy1;
    en.s2  = v1_r && rdy2;
    en.s3  = v2_r && rdy3;
    en.upd = interp && !sil2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_ch.valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en.s1) sil1_r <= in_ch.silence;
    if (en.s2) sil2_r <= sil1_r;
    if (en.s3) sil3_r <= sil2_r;
  end

  assign right_src = stereo_r ? in_ch.right_sample : in_ch.left_sample;

  pvu_lane #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_lane_l (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .sample (in_ch.left_sample),
    .volume (volume_r),
    .taps   (taps_l)
  );

  pvu_lane #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_lane_r (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .sample (right_src),
    .volume (volume_r),
    .taps   (taps_r)
  );

  pvu_merge #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .mode        (mode_r),
    .grp_valid   (v3_r),
    .grp_ready   (grp_ready),
    .grp_silence (sil3_r),
    .taps_l      (taps_l),
    .taps_r      (taps_r),
    .out_ch      (out_ch)
  );

endmodule
